// File: rtl/deq_pkg.sv
// Shared types and constants for the deque with remove-by-value.
// No dependencies; used by deq_cell and deque_with_remove_by_value_unit.
package deq_pkg;

  // Storage and field widths.
  localparam int DEPTH_DEFAULT = 16;
  localparam int ITEM_W        = 32;
  localparam int CMD_W         = 3;
  localparam int STATUS_W      = 2;
  localparam int LEN_W         = 5;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 40;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PEEK_BACK  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd6;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd3;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
    logic match_en;
    logic rem_exec;
  } cell_ctrl_t;

endpackage

// File: rtl/deq_cell.sv
// One storage position of the deque chain: an entry, its valid bit and a
// registered match flag. Depends on deq_pkg.
module deq_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  deq_pkg::cell_ctrl_t        ctrl,
  input  logic [deq_pkg::ITEM_W-1:0] item,
  input  logic [deq_pkg::ITEM_W-1:0] prev_data,
  input  logic                       prev_valid,
  input  logic [deq_pkg::ITEM_W-1:0] next_data,
  input  logic                       next_valid,
  input  logic                       seen_in,
  output logic [deq_pkg::ITEM_W-1:0] data,
  output logic                       valid,
  output logic                       seen_out
);

  logic match;

  // A match at or in front of this cell means this cell closes the gap.
  assign seen_out = seen_in | match;

  // Entry payload moves with the neighbors.
  always_ff @(posedge clk) begin
    priority if (ctrl.push_front) begin
      data <= prev_data;
    end else if (ctrl.push_back && !valid && prev_valid) begin
      data <= item;
    end else if (ctrl.pop_front || (ctrl.rem_exec && seen_out)) begin
      data <= next_data;
    end else begin
      data <= data;
    end
  end

  // Occupancy and match flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      priority if (ctrl.push_front) begin
        valid <= prev_valid;
      end else if (ctrl.push_back && prev_valid) begin
        valid <= 1'b1;
      end else if (ctrl.pop_front || (ctrl.rem_exec && seen_out)) begin
        valid <= next_valid;
      end else if (ctrl.pop_back && !next_valid) begin
        valid <= 1'b0;
      end else begin
        valid <= valid;
      end
      if (ctrl.match_en) begin
        match <= valid && (data == item);
      end else if (ctrl.rem_exec) begin
        match <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/deque_with_remove_by_value_unit.sv
// Top level of the bounded deque with remove-by-value.
// Depends on deq_pkg and deq_cell.

// A bounded double-ended queue of 32-bit handles, held in a chain of DEPTH
// cells ordered from the front (cell 0) to the back. Push and pop at the
// front shift the whole chain; at the back they touch only the back end;
// peeks leave it as it is. A remove first has every cell register whether
// its entry matches the handle; then, in the remove state, a one-bit carry
// runs from the first match, and that cell and every cell behind it take
// their neighbor's entry. A request is taken only when idle and the result
// register is free or being drained: one per cycle, though a remove holds
// off the next. Each request gives one result: item, status, length.
module deque_with_remove_by_value_unit #(
  parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // Fields from bit 0: command[2:0], item[34:3], zero padding[39:35].
  input  logic [deq_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // Fields from bit 0: item_out[31:0], status[33:32], length[38:34],
  // zero padding[39].
  output logic [deq_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_REMOVE = 1'b1;

  logic                              state;
  logic [CW-1:0]                     count;
  logic [CW-1:0]                     count_next;
  logic                              accept;
  logic [deq_pkg::CMD_W-1:0]         cmd;
  logic [deq_pkg::ITEM_W-1:0]        item;
  logic                              empty;
  logic                              full;
  deq_pkg::cell_ctrl_t               ctrl;
  logic [deq_pkg::ITEM_W-1:0]        cell_data [DEPTH];
  logic [DEPTH-1:0]                  cell_valid;
  logic [DEPTH:0]                    seen;
  logic [deq_pkg::ITEM_W-1:0]        back_data;
  logic                              found;
  logic [deq_pkg::ITEM_W-1:0]        out_item;
  logic [deq_pkg::STATUS_W-1:0]      out_status;
  logic [deq_pkg::LEN_W-1:0]         out_len;
  logic [deq_pkg::ITEM_W-1:0]        res_item;
  logic [deq_pkg::STATUS_W-1:0]      res_status;
  logic                              res_load;

  // Request side.
  assign cmd      = s_tdata[deq_pkg::CMD_W-1:0];
  assign item     = s_tdata[deq_pkg::CMD_W +: deq_pkg::ITEM_W];
  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign empty    = (count == '0);
  assign full     = (count == CW'(DEPTH));

  // Operation broadcast to the chain.
  always_comb begin
    ctrl            = '0;
    ctrl.push_front = accept && (cmd == deq_pkg::CMD_PUSH_FRONT) && !full;
    ctrl.push_back  = accept && (cmd == deq_pkg::CMD_PUSH_BACK) && !full;
    ctrl.pop_front  = accept && (cmd == deq_pkg::CMD_POP_FRONT) && !empty;
    ctrl.pop_back   = accept && (cmd == deq_pkg::CMD_POP_BACK) && !empty;
    ctrl.match_en   = accept && (cmd == deq_pkg::CMD_REMOVE);
    ctrl.rem_exec   = (state == S_REMOVE);
  end

  // The chain of cells; cell 0 sees the new handle as its front neighbor.
  assign seen[0] = 1'b0;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [deq_pkg::ITEM_W-1:0] prev_d;
    logic                       prev_v;
    logic [deq_pkg::ITEM_W-1:0] next_d;
    logic                       next_v;
    if (i == 0) begin : g_front
      assign prev_d = item;
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_d = cell_data[i-1];
      assign prev_v = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_back
      assign next_d = '0;
      assign next_v = 1'b0;
    end else begin : g_inner
      assign next_d = cell_data[i+1];
      assign next_v = cell_valid[i+1];
    end
    deq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .item       (item),
      .prev_data  (prev_d),
      .prev_valid (prev_v),
      .next_data  (next_d),
      .next_valid (next_v),
      .seen_in    (seen[i]),
      .data       (cell_data[i]),
      .valid      (cell_valid[i]),
      .seen_out   (seen[i+1])
    );
  end

  assign found     = seen[DEPTH];
  assign back_data = cell_data[IW'(count - CW'(1))];

  // Result of the request finishing this cycle, and the new length.
  always_comb begin
    res_item   = '0;
    res_status = deq_pkg::STAT_OK;
    res_load   = 1'b0;
    count_next = count;
    if (state == S_REMOVE) begin
      res_load = 1'b1;
      if (found) begin
        count_next = count - CW'(1);
      end else begin
        res_status = deq_pkg::STAT_NOT_FOUND;
      end
    end else if (accept && (cmd != deq_pkg::CMD_REMOVE)) begin
      res_load = 1'b1;
      unique case (cmd)
        deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            res_status = deq_pkg::STAT_FULL;
          end else begin
            count_next = count + CW'(1);
          end
        end
        deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_PEEK_FRONT: begin
          if (empty) begin
            res_status = deq_pkg::STAT_EMPTY;
          end else begin
            res_item = cell_data[0];
            if (cmd == deq_pkg::CMD_POP_FRONT) begin
              count_next = count - CW'(1);
            end
          end
        end
        deq_pkg::CMD_POP_BACK, deq_pkg::CMD_PEEK_BACK: begin
          if (empty) begin
            res_status = deq_pkg::STAT_EMPTY;
          end else begin
            res_item = back_data;
            if (cmd == deq_pkg::CMD_POP_BACK) begin
              count_next = count - CW'(1);
            end
          end
        end
        default: begin
          res_status = deq_pkg::STAT_OK;
        end
      endcase
    end
  end

  // Control state: sequencer, length and result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept && (cmd == deq_pkg::CMD_REMOVE)) begin
        state <= S_REMOVE;
      end else begin
        state <= S_IDLE;
      end
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_item   <= res_item;
      out_status <= res_status;
      out_len    <= deq_pkg::LEN_W'(count_next);
    end
  end

  assign m_tdata = {1'b0, out_len, out_status, out_item};

`ifndef SYNTHESIS
  // Length never exceeds the chain depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("deque length beyond depth");

  // Occupied cells always agree with the length.
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == int'(count))
    else $error("cell valid bits disagree with length");

  // Occupied cells form one run starting at the front.
  a_valid_packed: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid + 1'b1) & cell_valid) == '0)
    else $error("gap in occupied cells");

  // The remove state always leads in the following cycle to a result and idle.
  a_remove_done: assert property (@(posedge clk) disable iff (rst)
    state == S_REMOVE |=> m_tvalid && state == S_IDLE)
    else $error("remove did not produce a result");

  // No new request is taken while a remove is in progress.
  a_remove_block: assert property (@(posedge clk) disable iff (rst)
    state == S_REMOVE |-> !s_tready)
    else $error("request taken during remove");
`endif

endmodule
